// ----- rtl/sfp_pkg.sv -----
// Shared constants, codes and the CRC-16 byte update for the frame parser.
package sfp_pkg;

    localparam int unsigned MAX_PAYLOAD = 64;
    localparam int unsigned COUNT_W     = $clog2(MAX_PAYLOAD + 1);
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned NUM_SAMPLES = 4;
    localparam int unsigned NUM_FIRST   = 2 * NUM_SAMPLES;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    typedef enum logic [1:0] {
        OC_NONE = 2'd0,
        OC_GOOD = 2'd1,
        OC_BAD  = 2'd2,
        OC_LONG = 2'd3
    } t_outcome;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEAD   = 2'd0,
        CFG_MASK   = 2'd1,
        CFG_MATCH  = 2'd2,
        CFG_OFFSET = 2'd3
    } t_cfg_idx;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ----- rtl/sfp_in_if.sv -----
// Input channel: one received byte per item.
interface sfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ----- rtl/sfp_out_if.sv -----
// Result channel: parse outcome and held stick values per item.
interface sfp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  outcome;
    logic [7:0]  frame_id;
    logic [7:0]  stick_state;
    logic        values_fresh;
    logic [15:0] stick_a;
    logic [15:0] stick_b;
    logic [15:0] stick_c;
    logic [15:0] stick_d;

    modport source (output valid, output outcome, output frame_id, output stick_state,
                    output values_fresh, output stick_a, output stick_b, output stick_c,
                    output stick_d, input ready);
    modport sink   (input valid, input outcome, input frame_id, input stick_state,
                    input values_fresh, input stick_a, input stick_b, input stick_c,
                    input stick_d, output ready);
endinterface

// ----- rtl/stick_frame_parser_crc16_top.sv -----
// Serial frame parser with CRC-16 check and stick sample capture.
// The result item for an accepted byte is written to the output register in the cycle after it is accepted.
// Throughput: one byte per cycle unless a waiting result is not taken; the CRC is updated for a whole byte in one pass.
// The output register frees itself when taken, so a byte is accepted in the cycle a waiting result is taken.
// Reset (synchronous, active low) restores the configuration defaults, hunting state,
// CRC init and clears held values and the output register.
module stick_frame_parser_crc16_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [sfp_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [sfp_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    sfp_in_if.sink                             i_in,
    sfp_out_if.source                          o_out
);
    import sfp_pkg::*;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_ID   = 3'd1,
        PH_LEN  = 3'd2,
        PH_DATA = 3'd3,
        PH_CKLO = 3'd4,
        PH_CKHI = 3'd5
    } t_phase;

    logic [7:0]  r_head, r_mask, r_match;
    logic [15:0] r_offset;

    t_phase                          r_phase, n_phase;
    logic [7:0]                      r_id, n_id;
    logic [COUNT_W-1:0]              r_len, n_len;
    logic [COUNT_W-1:0]              r_count, n_count, w_count_inc;
    logic [15:0]                     r_crc, n_crc;
    logic [7:0]                      r_ck_lo, n_ck_lo;
    logic [NUM_FIRST-1:0][7:0]       r_first, n_first;
    logic [7:0]                      r_last, n_last;

    logic                            r_out_valid;
    t_outcome                        r_outcome, n_outcome;
    logic                            r_fresh, n_fresh;
    logic [7:0]                      r_frame_id, n_frame_id;
    logic [7:0]                      r_stick, n_stick;
    logic [NUM_SAMPLES-1:0][15:0]    r_samples, n_samples;

    logic       w_accept;
    logic [7:0] w_rx;

    assign w_rx        = i_in.rx_byte;
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign w_accept    = i_in.valid && i_in.ready;
    assign w_count_inc = r_count + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= 8'h55;
            r_mask   <= 8'hFF;
            r_match  <= 8'h00;
            r_offset <= 16'h0000;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_HEAD:   r_head   <= i_cfg_data[7:0];
                CFG_MASK:   r_mask   <= i_cfg_data[7:0];
                CFG_MATCH:  r_match  <= i_cfg_data[7:0];
                CFG_OFFSET: r_offset <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_id       = r_id;
        n_len      = r_len;
        n_count    = r_count;
        n_crc      = r_crc;
        n_ck_lo    = r_ck_lo;
        n_first    = r_first;
        n_last     = r_last;
        n_outcome  = OC_NONE;
        n_fresh    = 1'b0;
        n_frame_id = r_frame_id;
        n_stick    = r_stick;
        n_samples  = r_samples;
        case (r_phase)
            PH_ID: begin
                n_id    = w_rx;
                n_crc   = crc_feed(r_crc, w_rx);
                n_phase = PH_LEN;
            end
            PH_LEN: begin
                n_len   = w_rx[COUNT_W-1:0];
                n_count = '0;
                if (w_rx > 8'(MAX_PAYLOAD)) begin
                    n_outcome  = OC_LONG;
                    n_frame_id = r_id;
                    n_phase    = PH_HUNT;
                end else begin
                    n_crc   = crc_feed(r_crc, w_rx);
                    n_phase = (w_rx == 8'h00) ? PH_CKLO : PH_DATA;
                end
            end
            PH_DATA: begin
                n_crc = crc_feed(r_crc, w_rx);
                if (r_count < COUNT_W'(NUM_FIRST)) begin
                    n_first[r_count[$clog2(NUM_FIRST)-1:0]] = w_rx;
                end
                n_last  = w_rx;
                n_count = w_count_inc;
                if (w_count_inc >= r_len) begin
                    n_phase = PH_CKLO;
                end
            end
            PH_CKLO: begin
                n_ck_lo = w_rx;
                n_phase = PH_CKHI;
            end
            PH_CKHI: begin
                n_frame_id = r_id;
                n_phase    = PH_HUNT;
                if ({w_rx, r_ck_lo} == r_crc) begin
                    n_outcome = OC_GOOD;
                    if (r_len != '0) begin
                        n_stick = r_last;
                    end
                    if (((r_id & r_mask) == r_match) && (r_len >= COUNT_W'(NUM_FIRST))) begin
                        for (int k = 0; k < NUM_SAMPLES; k++) begin
                            n_samples[k] = {r_first[2*k+1], r_first[2*k]} + r_offset;
                        end
                        n_fresh = 1'b1;
                    end
                end else begin
                    n_outcome = OC_BAD;
                end
            end
            default: begin
                n_phase = PH_HUNT;
                if (w_rx == r_head) begin
                    n_crc   = crc_feed(CRC_INIT, w_rx);
                    n_phase = PH_ID;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_id        <= '0;
            r_len       <= '0;
            r_count     <= '0;
            r_crc       <= CRC_INIT;
            r_ck_lo     <= '0;
            r_first     <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
            r_outcome   <= OC_NONE;
            r_fresh     <= 1'b0;
            r_frame_id  <= '0;
            r_stick     <= '0;
            r_samples   <= '0;
        end else begin
            if (w_accept) begin
                r_phase    <= n_phase;
                r_id       <= n_id;
                r_len      <= n_len;
                r_count    <= n_count;
                r_crc      <= n_crc;
                r_ck_lo    <= n_ck_lo;
                r_first    <= n_first;
                r_last     <= n_last;
                r_outcome  <= n_outcome;
                r_fresh    <= n_fresh;
                r_frame_id <= n_frame_id;
                r_stick    <= n_stick;
                r_samples  <= n_samples;
            end
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.outcome      = r_outcome;
    assign o_out.frame_id     = r_frame_id;
    assign o_out.stick_state  = r_stick;
    assign o_out.values_fresh = r_fresh;
    assign o_out.stick_a      = r_samples[0];
    assign o_out.stick_b      = r_samples[1];
    assign o_out.stick_c      = r_samples[2];
    assign o_out.stick_d      = r_samples[3];

    // fresh samples only ever come with a good frame
    a_fresh_good: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fresh |-> (r_outcome == OC_GOOD))
        else $error("values_fresh without good outcome");

    a_data_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> ((r_len != '0) && (r_count < r_len)
                                  && (r_len <= COUNT_W'(MAX_PAYLOAD))))
        else $error("payload count out of range");

    a_ckhi_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (r_phase == PH_CKHI)) |=> ((r_phase == PH_HUNT) && (r_outcome != OC_NONE)))
        else $error("checksum byte did not end the frame");

    a_done_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (n_outcome != OC_NONE)) |=> (r_frame_id == $past(r_id)))
        else $error("frame id not taken from held id");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready && !i_in.valid) |=> (r_out_valid && $stable(r_samples)))
        else $error("waiting result lost");

endmodule

// ----- dv/stick_frame_parser_crc16_top_test.sv -----
// Self-checking testbench for the serial frame parser: directed script, then random frame traffic.
module stick_frame_parser_crc16_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sfp_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned PHASE_ITEMS  = 410;
    localparam int unsigned MAX_REPORTED = 10;

    typedef enum logic [2:0] {
        P_HUNT = 3'd0,
        P_ID   = 3'd1,
        P_LEN  = 3'd2,
        P_DATA = 3'd3,
        P_CKLO = 3'd4,
        P_CKHI = 3'd5
    } t_parse_phase;

    typedef struct packed {
        t_outcome    outcome;
        logic [7:0]  frame_id;
        logic [7:0]  stick_state;
        logic        values_fresh;
        logic [15:0] stick_a;
        logic [15:0] stick_b;
        logic [15:0] stick_c;
        logic [15:0] stick_d;
    } t_result;

    typedef enum logic [1:0] {
        ROW_BYTE    = 2'd0,
        ROW_CRC_LO  = 2'd1,
        ROW_CRC_HI  = 2'd2,
        ROW_CRC_BAD = 2'd3
    } t_row_kind;

    typedef struct packed {
        t_row_kind kind;
        logic [7:0] value;
        logic       typed;
        t_result    want;
    } t_script_row;

    localparam t_result AFTER_RESET = '0;

    // checksum rows take their byte from the running CRC of the frame in flight
    t_script_row opening_script [0:26] = '{
        '{ROW_BYTE,    8'hAA, 1'b1, AFTER_RESET},
        '{ROW_BYTE,    8'h55, 1'b0, AFTER_RESET},
        '{ROW_BYTE,    8'hFF, 1'b0, AFTER_RESET},
        '{ROW_BYTE,    8'h41, 1'b1,
          '{OC_LONG, 8'hFF, 8'h00, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000}},
        '{ROW_BYTE,    8'h55, 1'b0, AFTER_RESET},
        '{ROW_BYTE,    8'h00, 1'b0, AFTER_RESET},
        '{ROW_BYTE,    8'h00, 1'b0, AFTER_RESET},
        '{ROW_CRC_LO,  8'h00, 1'b0, AFTER_RESET},
        '{ROW_CRC_HI,  8'h00, 1'b1,
          '{OC_GOOD, 8'h00, 8'h00, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000}},
        '{ROW_BYTE,    8'h55, 1'b0, AFTER_RESET},
        '{ROW_BYTE,    8'h00, 1'b0, AFTER_RESET},
        '{ROW_BYTE,    8'h08, 1'b0, AFTER_RESET},
        '{ROW_BYTE,    8'h00, 1'b0, AFTER_RESET},
        '{ROW_BYTE,    8'h80, 1'b0, AFTER_RESET},
        '{ROW_BYTE,    8'hFF, 1'b0, AFTER_RESET},
        '{ROW_BYTE,    8'h7F, 1'b0, AFTER_RESET},
        '{ROW_BYTE,    8'hFF, 1'b0, AFTER_RESET},
        '{ROW_BYTE,    8'hFF, 1'b0, AFTER_RESET},
        '{ROW_BYTE,    8'h01, 1'b0, AFTER_RESET},
        '{ROW_BYTE,    8'h00, 1'b0, AFTER_RESET},
        '{ROW_CRC_LO,  8'h00, 1'b0, AFTER_RESET},
        '{ROW_CRC_HI,  8'h00, 1'b0, AFTER_RESET},
        '{ROW_BYTE,    8'h55, 1'b0, AFTER_RESET},
        '{ROW_BYTE,    8'h07, 1'b0, AFTER_RESET},
        '{ROW_BYTE,    8'h00, 1'b0, AFTER_RESET},
        '{ROW_CRC_LO,  8'h00, 1'b0, AFTER_RESET},
        '{ROW_CRC_BAD, 8'h00, 1'b0, AFTER_RESET}
    };

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    sfp_in_if  rx_chan ();
    sfp_out_if res_chan ();

    stick_frame_parser_crc16_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (rx_chan.sink),
        .o_out      (res_chan.source)
    );

    // configuration mirror
    logic [7:0]  cfg_head   = 8'h55;
    logic [7:0]  cfg_mask   = 8'hFF;
    logic [7:0]  cfg_match  = 8'h00;
    logic [15:0] cfg_offset = 16'h0000;

    // parser state mirror
    t_parse_phase rx_phase = P_HUNT;
    logic [7:0]   rx_id    = 8'h00;
    logic [7:0]   rx_len   = 8'h00;
    logic [7:0]   rx_count = 8'h00;
    logic [15:0]  rx_crc   = CRC_INIT;
    logic [7:0]   rx_ck_lo = 8'h00;
    logic [7:0]   rx_first [NUM_FIRST]   = '{default: 8'h00};
    logic [7:0]   rx_last  = 8'h00;
    logic [15:0]  held_samples [NUM_SAMPLES] = '{default: 16'h0000};
    logic [7:0]   held_stick = 8'h00;
    logic [7:0]   done_id    = 8'h00;

    t_result     parse_results_due [$];
    int unsigned faults      = 0;
    int unsigned cycle_count = 0;
    int unsigned items_sent  = 0;
    int unsigned gap_pct     = 0;
    int unsigned stall_pct   = 0;

    function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = acc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ b[i];
            c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

    function automatic t_result parse_byte(input logic [7:0] b);
        t_result r;
        r = AFTER_RESET;
        case (rx_phase)
            P_ID: begin
                rx_id    = b;
                rx_crc   = crc16_step(rx_crc, b);
                rx_phase = P_LEN;
            end
            P_LEN: begin
                rx_len   = b;
                rx_count = 8'h00;
                if (b > MAX_PAYLOAD) begin
                    r.outcome = OC_LONG;
                    done_id   = rx_id;
                    rx_phase  = P_HUNT;
                end else begin
                    rx_crc   = crc16_step(rx_crc, b);
                    rx_phase = (b == 8'h00) ? P_CKLO : P_DATA;
                end
            end
            P_DATA: begin
                rx_crc = crc16_step(rx_crc, b);
                if (rx_count < NUM_FIRST) begin
                    rx_first[rx_count[2:0]] = b;
                end
                rx_last  = b;
                rx_count = rx_count + 8'd1;
                if (rx_count >= rx_len) begin
                    rx_phase = P_CKLO;
                end
            end
            P_CKLO: begin
                rx_ck_lo = b;
                rx_phase = P_CKHI;
            end
            P_CKHI: begin
                done_id  = rx_id;
                rx_phase = P_HUNT;
                if ({b, rx_ck_lo} == rx_crc) begin
                    r.outcome = OC_GOOD;
                    if (rx_len != 8'h00) begin
                        held_stick = rx_last;
                    end
                    if (((rx_id & cfg_mask) == cfg_match) && (rx_len >= 8'd8)) begin
                        for (int k = 0; k < NUM_SAMPLES; k++) begin
                            held_samples[k] = {rx_first[2*k+1], rx_first[2*k]} + cfg_offset;
                        end
                        r.values_fresh = 1'b1;
                    end
                end else begin
                    r.outcome = OC_BAD;
                end
            end
            default: begin
                rx_phase = P_HUNT;
                if (b == cfg_head) begin
                    rx_crc   = crc16_step(CRC_INIT, b);
                    rx_phase = P_ID;
                end
            end
        endcase
        r.frame_id    = done_id;
        r.stick_state = held_stick;
        r.stick_a     = held_samples[0];
        r.stick_b     = held_samples[1];
        r.stick_c     = held_samples[2];
        r.stick_d     = held_samples[3];
        return r;
    endfunction

    task automatic push_rx(input logic [7:0] b, input logic typed, input t_result typed_res);
        t_result r;
        while ($urandom_range(0, 99) < gap_pct) begin
            rx_chan.valid <= 1'b0;
            @(posedge i_clk);
        end
        rx_chan.valid   <= 1'b1;
        rx_chan.rx_byte <= b;
        @(posedge i_clk);
        while (rx_chan.ready !== 1'b1) begin
            @(posedge i_clk);
        end
        r = parse_byte(b);
        parse_results_due.push_back(typed ? typed_res : r);
        items_sent++;
    endtask

    // sender holds off until every pending result has been taken
    task automatic drain_results();
        rx_chan.valid <= 1'b0;
        @(posedge i_clk);
        wait (parse_results_due.size() == 0);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_HEAD:   cfg_head   = data[7:0];
            CFG_MASK:   cfg_mask   = data[7:0];
            CFG_MATCH:  cfg_match  = data[7:0];
            CFG_OFFSET: cfg_offset = data;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [7:0] head, input logic [7:0] mask,
                              input logic [7:0] match, input logic [15:0] offset);
        drain_results();
        write_reg(CFG_HEAD,   {8'h00, head});
        write_reg(CFG_MASK,   {8'h00, mask});
        write_reg(CFG_MATCH,  {8'h00, match});
        write_reg(CFG_OFFSET, offset);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // mostly well-formed frames; the rest noise, over-long, corrupted or cut short
    task automatic send_mixed_sequence();
        logic [7:0]  seq [$];
        logic [15:0] crc;
        logic [7:0]  len;
        int unsigned pick;
        int unsigned sel;
        int unsigned pos;
        int unsigned cut;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            repeat ($urandom_range(1, 6)) begin
                seq.push_back(($urandom_range(0, 3) == 0) ? cfg_head : 8'($urandom));
            end
        end else begin
            seq.push_back(cfg_head);
            seq.push_back(($urandom_range(0, 1) == 1) ?
                          ((cfg_match & cfg_mask) | (8'($urandom) & ~cfg_mask)) : 8'($urandom));
            if (pick < 14) begin
                seq.push_back(8'($urandom_range(MAX_PAYLOAD + 1, 255)));
            end else begin
                sel = $urandom_range(0, 99);
                if (sel < 10) begin
                    len = 8'd0;
                end else if (sel < 45) begin
                    len = 8'($urandom_range(1, 7));
                end else if (sel < 80) begin
                    len = 8'($urandom_range(8, 12));
                end else if (sel < 93) begin
                    len = 8'($urandom_range(13, 32));
                end else if (sel < 97) begin
                    len = 8'($urandom_range(33, MAX_PAYLOAD - 1));
                end else begin
                    len = 8'(MAX_PAYLOAD);
                end
                seq.push_back(len);
                repeat (len) seq.push_back(8'($urandom));
                crc = CRC_INIT;
                foreach (seq[i]) crc = crc16_step(crc, seq[i]);
                seq.push_back(crc[7:0]);
                seq.push_back(crc[15:8]);
                if (pick < 22) begin
                    pos = $urandom_range(3, seq.size() - 1);
                    seq[pos] = seq[pos] ^ (8'h01 << $urandom_range(0, 7));
                end else if (pick < 26) begin
                    cut = $urandom_range(1, seq.size() - 1);
                    while (seq.size() > cut) void'(seq.pop_back());
                end
            end
        end
        foreach (seq[i]) push_rx(seq[i], 1'b0, AFTER_RESET);
    endtask

    task automatic run_random_phase(input int unsigned n, input int unsigned gap,
                                    input int unsigned stall);
        int unsigned start;
        gap_pct   = gap;
        stall_pct = stall;
        start     = items_sent;
        while (items_sent - start < n) begin
            send_mixed_sequence();
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            faults++;
            if (faults <= MAX_REPORTED) begin
                $display("mismatch on %s: expected %h, got %h", name, want, got);
            end
        end
    endtask

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        res_chan.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge i_clk) begin : watch_results
        t_result want;
        if (i_rst_n === 1'b1 && res_chan.valid === 1'b1 && res_chan.ready === 1'b1) begin
            if (parse_results_due.size() == 0) begin
                faults++;
                if (faults <= MAX_REPORTED) begin
                    $display("result item with none pending: outcome %h id %h",
                             res_chan.outcome, res_chan.frame_id);
                end
            end else begin
                want = parse_results_due.pop_front();
                check_field("outcome",      16'(want.outcome),      16'(res_chan.outcome));
                check_field("frame_id",     16'(want.frame_id),     16'(res_chan.frame_id));
                check_field("stick_state",  16'(want.stick_state),  16'(res_chan.stick_state));
                check_field("values_fresh", 16'(want.values_fresh), 16'(res_chan.values_fresh));
                check_field("stick_a",      want.stick_a,      res_chan.stick_a);
                check_field("stick_b",      want.stick_b,      res_chan.stick_b);
                check_field("stick_c",      want.stick_c,      res_chan.stick_c);
                check_field("stick_d",      want.stick_d,      res_chan.stick_d);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        logic [7:0] b;
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = CFG_HEAD;
        i_cfg_data      = '0;
        rx_chan.valid   = 1'b0;
        rx_chan.rx_byte = 8'h00;
        res_chan.ready  = 1'b1;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (opening_script[i]) begin
            case (opening_script[i].kind)
                ROW_CRC_LO:  b = rx_crc[7:0];
                ROW_CRC_HI:  b = rx_crc[15:8];
                ROW_CRC_BAD: b = rx_crc[15:8] ^ 8'h80;
                default:     b = opening_script[i].value;
            endcase
            push_rx(b, opening_script[i].typed, opening_script[i].want);
        end

        set_config(8'h00, 8'hFF, 8'h3C, 16'h0000);
        run_random_phase(PHASE_ITEMS, 0, 0);
        set_config(8'hFF, 8'h00, 8'h00, 16'hFFFF);
        run_random_phase(PHASE_ITEMS, 57, 0);
        set_config(8'($urandom), 8'($urandom), 8'($urandom), 16'h8000);
        run_random_phase(PHASE_ITEMS, 0, 57);
        set_config(8'h55, 8'hF0, 8'hA0, 16'($urandom));
        run_random_phase(PHASE_ITEMS, 14, 14);

        drain_results();
        if (faults == 0 && parse_results_due.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
